@@ hw/rtl/resp_pkg.sv @@
// ----------------------------------------------------------------------------
// resp_pkg: shared types and constants of the encoder servo setpoint core
// Transaction payloads, configuration set, tracked state and code values.
// ----------------------------------------------------------------------------
package resp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned QuietW   = 4;
  localparam int unsigned PwW      = 12;
  localparam int unsigned StepW    = 10;
  localparam int unsigned EvW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSettle    = 3'd0,
    CfgStep      = 3'd1,
    CfgLowLimit  = 3'd2,
    CfgHighLimit = 3'd3,
    CfgInitWidth = 3'd4
  } cfg_idx_e;

  localparam logic [EvW-1:0] EvNone     = 3'd0;
  localparam logic [EvW-1:0] EvLeft     = 3'd1;
  localparam logic [EvW-1:0] EvRight    = 3'd2;
  localparam logic [EvW-1:0] EvLeftLim  = 3'd3;
  localparam logic [EvW-1:0] EvRightLim = 3'd4;
  localparam logic [EvW-1:0] EvError    = 3'd5;
  localparam logic [EvW-1:0] EvHalted   = 3'd6;

  localparam logic [QuietW-1:0] SettleRst   = 4'd10;
  localparam logic [StepW-1:0]  StepRst     = 10'd250;
  localparam logic [PwW-1:0]    LowLimRst   = 12'd180;
  localparam logic [PwW-1:0]    HighLimRst  = 12'd2600;
  localparam logic [PwW-1:0]    InitWidth   = 12'd1000;
  localparam logic [QuietW-1:0] QuietMax    = 4'd15;
  localparam logic [PwW-1:0]    WidthMax    = 12'd4095;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic button_n;
  } in_t;

  typedef struct packed {
    logic [EvW-1:0] event_res;
    logic [PwW-1:0] width_us;
    logic           fire;
    logic           led;
  } out_t;

  typedef struct packed {
    logic [QuietW-1:0] settle_samples;
    logic [StepW-1:0]  step_size;
    logic [PwW-1:0]    low_limit;
    logic [PwW-1:0]    high_limit;
  } cfg_t;

  typedef struct packed {
    logic              last_a;
    logic              last_b;
    logic [QuietW-1:0] quiet_count;
    logic [PwW-1:0]    pulse_width;
    logic              halted;
  } state_t;

endpackage

@@ hw/rtl/rotary_encoder_servo_setpoint_core.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_servo_setpoint_core: encoder knob to servo width setpoint
// Input register, single-pass decode logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) carries one
//   sample of encoder lines A, B and the active-low button per transaction.
//   The output channel (out_valid_o / out_stall_i / out_data_o) returns one
//   result per sample: event code, pulse width, fire and led flags.
//   A result is decoded from the input register into the result register;
//   one sample is taken every cycle unless the output is stalled, and the
//   single register-to-register decode pass updates the encoder state.
//   The result register holds its transaction while out_stall_i is high;
//   an empty input register still takes one more sample, and while both
//   registers hold a transaction in_stall_o follows out_stall_i in the same cycle.
//   Reset clears both valid flags, loads the default configuration and sets
//   the width to its default of 1000 us. The user must write configuration
//   registers via cfg_we_i/cfg_idx_i/cfg_data_i only while idle (not enforced).
// ----------------------------------------------------------------------------
module rotary_encoder_servo_setpoint_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [resp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [resp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  resp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output resp_pkg::out_t                out_data_o
);

  resp_pkg::cfg_t   cfg;
  resp_pkg::state_t state_q;
  resp_pkg::state_t state_d;
  resp_pkg::out_t   res;
  resp_pkg::out_t   out_q;
  resp_pkg::in_t    in_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             step_en;

  resp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  resp_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .sample_i (in_q),
    .state_o  (state_d),
    .res_o    (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.last_a      <= 1'b1;
      state_q.last_b      <= 1'b1;
      state_q.quiet_count <= '0;
      state_q.pulse_width <= resp_pkg::InitWidth;
      state_q.halted      <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step_en) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (step_en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/resp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// resp_cfg_regs: configuration register bank
// Write-only registers selected by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module resp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [resp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [resp_pkg::CfgDataW-1:0] cfg_data_i,
  output resp_pkg::cfg_t                cfg_o
);

  resp_pkg::cfg_t cfg_q;
  resp_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (resp_pkg::cfg_idx_e'(cfg_idx_i))
        resp_pkg::CfgSettle:    cfg_d.settle_samples = cfg_data_i[resp_pkg::QuietW-1:0];
        resp_pkg::CfgStep:      cfg_d.step_size      = cfg_data_i[resp_pkg::StepW-1:0];
        resp_pkg::CfgLowLimit:  cfg_d.low_limit      = cfg_data_i[resp_pkg::PwW-1:0];
        resp_pkg::CfgHighLimit: cfg_d.high_limit     = cfg_data_i[resp_pkg::PwW-1:0];
        // reset always restores the default width, so this write has no effect
        resp_pkg::CfgInitWidth: cfg_d = cfg_q;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_samples <= resp_pkg::SettleRst;
      cfg_q.step_size      <= resp_pkg::StepRst;
      cfg_q.low_limit      <= resp_pkg::LowLimRst;
      cfg_q.high_limit     <= resp_pkg::HighLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/resp_step.sv @@
// ----------------------------------------------------------------------------
// resp_step: per-sample decode logic
// Halt on button press, debounce, detent decode, limit check and saturating width update.
// ----------------------------------------------------------------------------
module resp_step (
  input  resp_pkg::cfg_t   cfg_i,
  input  resp_pkg::state_t state_i,
  input  resp_pkg::in_t    sample_i,
  output resp_pkg::state_t state_o,
  output resp_pkg::out_t   res_o
);

  logic [resp_pkg::QuietW-1:0] quiet;
  logic                        changed;
  logic                        settling;
  logic [resp_pkg::PwW:0]      sum;
  logic [resp_pkg::PwW-1:0]    step_ext;

  always_comb begin
    state_o        = state_i;
    res_o.event_res = resp_pkg::EvNone;
    res_o.fire     = 1'b0;
    res_o.led      = 1'b0;
    step_ext       = {{(resp_pkg::PwW-resp_pkg::StepW){1'b0}}, cfg_i.step_size};
    sum            = {1'b0, state_i.pulse_width} + {1'b0, step_ext};
    quiet          = (state_i.quiet_count < resp_pkg::QuietMax) ?
                     state_i.quiet_count + 1'b1 : state_i.quiet_count;
    changed        = (sample_i.line_a != state_i.last_a) ||
                     (sample_i.line_b != state_i.last_b);
    settling       = changed && (quiet < cfg_i.settle_samples);

    if (state_i.halted) begin
      res_o.event_res = resp_pkg::EvHalted;
    end else if (!sample_i.button_n) begin
      state_o.halted  = 1'b1;
      res_o.event_res = resp_pkg::EvHalted;
      res_o.led       = 1'b1;
    end else if (settling) begin
      state_o.quiet_count = '0;
    end else begin
      state_o.quiet_count = quiet;
      if (changed && sample_i.line_a && sample_i.line_b) begin
        state_o.quiet_count = '0;
        if (state_i.last_a && !state_i.last_b) begin
          if (state_i.pulse_width < cfg_i.low_limit) begin
            res_o.event_res = resp_pkg::EvLeftLim;
          end else begin
            res_o.event_res     = resp_pkg::EvLeft;
            res_o.fire          = 1'b1;
            state_o.pulse_width = (state_i.pulse_width >= step_ext) ?
                                  state_i.pulse_width - step_ext : '0;
          end
        end else if (!state_i.last_a && state_i.last_b) begin
          if (state_i.pulse_width > cfg_i.high_limit) begin
            res_o.event_res = resp_pkg::EvRightLim;
          end else begin
            res_o.event_res     = resp_pkg::EvRight;
            res_o.fire          = 1'b1;
            state_o.pulse_width = sum[resp_pkg::PwW] ? resp_pkg::WidthMax :
                                  sum[resp_pkg::PwW-1:0];
          end
        end else begin
          res_o.event_res = resp_pkg::EvError;
        end
      end
      state_o.last_a = sample_i.line_a;
      state_o.last_b = sample_i.line_b;
    end
    res_o.width_us = state_o.pulse_width;
  end

endmodule

@@ hw/rtl/resp_checker.sv @@
// ----------------------------------------------------------------------------
// resp_checker: port-level checks of the encoder servo setpoint core
// Output hold, input stall, result flag consistency; bound to the top level.
// ----------------------------------------------------------------------------
module resp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input resp_pkg::out_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output stage free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fire |->
      out_data_o.event_res == resp_pkg::EvLeft || out_data_o.event_res == resp_pkg::EvRight)
    else $error("fire without a taken step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.led |->
      out_data_o.event_res == resp_pkg::EvHalted && !out_data_o.fire)
    else $error("led without halt event");

endmodule

bind rotary_encoder_servo_setpoint_core resp_checker u_resp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: encoder knob to servo width setpoint core testbench
// Drives encoder samples with random gaps and result stalls, predicts each
// result with a local model of the debounce, detent stepping, limits and
// halt or takes it from the intro table, and compares each one field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 225;
  localparam logic [resp_pkg::CfgIdxW-1:0] CfgUnused = 3'd7;
  // Gray sequences from detent to detent, last step decides the direction
  localparam logic [7:0] LeftTurn  = {2'b01, 2'b00, 2'b10, 2'b11};
  localparam logic [7:0] RightTurn = {2'b10, 2'b00, 2'b01, 2'b11};

  typedef struct packed {
    logic                          is_cfg;
    logic [resp_pkg::CfgIdxW-1:0]  idx;
    logic [resp_pkg::CfgDataW-1:0] data;
    resp_pkg::in_t                 smp;
    logic                          typed;
    resp_pkg::out_t                want;
  } row_t;

  localparam int IntroLen = 23;
  localparam row_t Intro [IntroLen] = '{
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvNone, 12'd1000, 1'b0, 1'b0}},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b101, 1'b1,
      '{resp_pkg::EvNone, 12'd1000, 1'b0, 1'b0}},
    '{1'b1, resp_pkg::CfgSettle, 12'd0, 3'b000, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b101, 1'b1,
      '{resp_pkg::EvNone, 12'd1000, 1'b0, 1'b0}},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvLeft, 12'd750, 1'b1, 1'b0}},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b011, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvRight, 12'd1000, 1'b1, 1'b0}},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b001, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvError, 12'd1000, 1'b0, 1'b0}},
    '{1'b1, resp_pkg::CfgStep, 12'd1023, 3'b000, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b101, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvLeft, 12'd0, 1'b1, 1'b0}},
    '{1'b1, resp_pkg::CfgLowLimit, 12'd4095, 3'b000, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b101, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvLeftLim, 12'd0, 1'b0, 1'b0}},
    '{1'b1, resp_pkg::CfgHighLimit, 12'd0, 3'b000, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b011, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvRight, 12'd1023, 1'b1, 1'b0}},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b011, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvRightLim, 12'd1023, 1'b0, 1'b0}},
    '{1'b1, resp_pkg::CfgInitWidth, 12'd4095, 3'b000, 1'b0, '0},
    '{1'b1, CfgUnused, 12'd4095, 3'b000, 1'b0, '0},
    '{1'b0, resp_pkg::CfgSettle, 12'd0, 3'b111, 1'b1,
      '{resp_pkg::EvNone, 12'd1023, 1'b0, 1'b0}}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [resp_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [resp_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  resp_pkg::in_t                 in_data = '1;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  resp_pkg::out_t                out_data;

  logic                          calm = 1'b0;
  int unsigned                   sent = 0;
  int unsigned                   mismatches = 0;
  int unsigned                   idle_cycles = 0;
  resp_pkg::out_t                pending_results [$];

  resp_pkg::state_t              knob;
  resp_pkg::cfg_t                knob_cfg;

  rotary_encoder_servo_setpoint_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk = ~clk;

  function automatic resp_pkg::out_t knob_step(resp_pkg::in_t smp);
    resp_pkg::out_t           r;
    logic [resp_pkg::PwW:0]   sum;
    logic [resp_pkg::PwW-1:0] step;
    logic                     bounce;
    r = '0;
    bounce = 1'b0;
    step = {{(resp_pkg::PwW-resp_pkg::StepW){1'b0}}, knob_cfg.step_size};
    if (knob.halted) begin
      r.event_res = resp_pkg::EvHalted;
    end else if (!smp.button_n) begin
      knob.halted = 1'b1;
      r.event_res = resp_pkg::EvHalted;
      r.led = 1'b1;
    end else begin
      if (knob.quiet_count < resp_pkg::QuietMax) begin
        knob.quiet_count = knob.quiet_count + 1'b1;
      end
      if (smp.line_a != knob.last_a || smp.line_b != knob.last_b) begin
        if (knob.quiet_count < knob_cfg.settle_samples) begin
          knob.quiet_count = '0;
          bounce = 1'b1;
        end else if (smp.line_a && smp.line_b) begin
          if (knob.last_a && !knob.last_b) begin
            if (knob.pulse_width < knob_cfg.low_limit) begin
              r.event_res = resp_pkg::EvLeftLim;
            end else begin
              r.event_res = resp_pkg::EvLeft;
              r.fire = 1'b1;
              knob.pulse_width = (knob.pulse_width >= step) ?
                                 knob.pulse_width - step : '0;
            end
          end else if (!knob.last_a && knob.last_b) begin
            if (knob.pulse_width > knob_cfg.high_limit) begin
              r.event_res = resp_pkg::EvRightLim;
            end else begin
              r.event_res = resp_pkg::EvRight;
              r.fire = 1'b1;
              sum = {1'b0, knob.pulse_width} + {1'b0, step};
              knob.pulse_width = sum[resp_pkg::PwW] ? resp_pkg::WidthMax :
                                 sum[resp_pkg::PwW-1:0];
            end
          end else begin
            r.event_res = resp_pkg::EvError;
          end
          knob.quiet_count = '0;
        end
      end
      if (!bounce) begin
        knob.last_a = smp.line_a;
        knob.last_b = smp.line_b;
      end
    end
    r.width_us = knob.pulse_width;
    return r;
  endfunction

  task automatic send(resp_pkg::in_t smp, logic typed, resp_pkg::out_t want);
    resp_pkg::out_t predicted;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = knob_step(smp);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic hold_level(logic [1:0] ab, int n);
    repeat (n) send({ab, 1'b1}, 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [resp_pkg::CfgIdxW-1:0] idx,
                           logic [resp_pkg::CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      resp_pkg::CfgSettle:    knob_cfg.settle_samples = data[resp_pkg::QuietW-1:0];
      resp_pkg::CfgStep:      knob_cfg.step_size = data[resp_pkg::StepW-1:0];
      resp_pkg::CfgLowLimit:  knob_cfg.low_limit = data[resp_pkg::PwW-1:0];
      resp_pkg::CfgHighLimit: knob_cfg.high_limit = data[resp_pkg::PwW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_knob(int settle, int step, int lo, int hi);
    wait_idle();
    write_reg(resp_pkg::CfgSettle, 12'(settle));
    write_reg(resp_pkg::CfgStep, 12'(step));
    write_reg(resp_pkg::CfgLowLimit, 12'(lo));
    write_reg(resp_pkg::CfgHighLimit, 12'(hi));
  endtask

  task automatic run_phase(int n, int pause_at);
    int unsigned start;
    int          kind;
    int          lv;
    int          steps;
    logic [7:0]  turn;
    logic [1:0]  ab;
    start = sent;
    while (sent - start < n) begin
      kind = $urandom_range(99);
      turn = $urandom_range(1) ? LeftTurn : RightTurn;
      if (kind < 70) begin
        for (lv = 0; lv < 4; lv++) begin
          if ($urandom_range(99) < 10) begin
            ab = 2'($urandom_range(3));
            send({ab, 1'b1}, 1'b0, '0);
          end
          hold_level(turn[7-2*lv -: 2],
                     $urandom_range(1, int'(knob_cfg.settle_samples) + 3));
        end
      end else if (kind < 85) begin
        // abandon the turn part way and snap back to the detent
        steps = $urandom_range(1, 3);
        for (lv = 0; lv < steps; lv++) begin
          hold_level(turn[7-2*lv -: 2],
                     $urandom_range(1, int'(knob_cfg.settle_samples) + 3));
        end
        hold_level(2'b11, $urandom_range(1, int'(knob_cfg.settle_samples) + 3));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          ab = 2'($urandom_range(3));
          send({ab, 1'b1}, 1'b0, '0);
        end
      end
      if (pause_at > 0 && sent - start >= pause_at) begin
        wait_idle();
        pause_at = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    resp_pkg::out_t want;
    out_stall <= !calm && ($urandom_range(99) < 36);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.event_res != want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_data.event_res);
          mismatches++;
        end
        if (out_data.width_us != want.width_us) begin
          $error("width_us: expected %0d, got %0d", want.width_us, out_data.width_us);
          mismatches++;
        end
        if (out_data.fire != want.fire) begin
          $error("fire: expected %0d, got %0d", want.fire, out_data.fire);
          mismatches++;
        end
        if (out_data.led != want.led) begin
          $error("led: expected %0d, got %0d", want.led, out_data.led);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int            i;
    resp_pkg::in_t smp;
    knob = '{last_a: 1'b1, last_b: 1'b1, quiet_count: '0,
             pulse_width: resp_pkg::InitWidth, halted: 1'b0};
    knob_cfg = '{settle_samples: resp_pkg::SettleRst, step_size: resp_pkg::StepRst,
                 low_limit: resp_pkg::LowLimRst, high_limit: resp_pkg::HighLimRst};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < IntroLen; i++) begin
      if (Intro[i].is_cfg) begin
        wait_idle();
        write_reg(Intro[i].idx, Intro[i].data);
      end else begin
        send(Intro[i].smp, Intro[i].typed, Intro[i].want);
      end
    end

    set_knob(resp_pkg::SettleRst, resp_pkg::StepRst, resp_pkg::LowLimRst,
             resp_pkg::HighLimRst);
    write_reg(resp_pkg::CfgInitWidth, '0);
    run_phase(PhaseItems, 0);
    calm = 1'b1;
    set_knob(0, 1023, 0, 4095);
    run_phase(PhaseItems, 0);
    calm = 1'b0;
    set_knob(15, 0, 4095, 0);
    run_phase(PhaseItems, PhaseItems / 2);
    set_knob(1, 1023, $urandom_range(0, 4095), $urandom_range(0, 4095));
    run_phase(PhaseItems, 0);
    set_knob($urandom_range(1, 6), $urandom_range(0, 1023), $urandom_range(0, 2047),
             $urandom_range(2048, 4095));
    run_phase(PhaseItems, 0);
    set_knob($urandom_range(0, 15), $urandom_range(0, 1023), $urandom_range(0, 4095),
             $urandom_range(0, 4095));
    run_phase(PhaseItems, 0);

    // press the knob, then everything after is ignored
    send(3'b110, 1'b0, '0);
    repeat (24) begin
      smp = 3'($urandom_range(7));
      send(smp, 1'b0, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ rotary_encoder_servo_setpoint_core.f @@
hw/rtl/resp_pkg.sv
hw/rtl/resp_cfg_regs.sv
hw/rtl/resp_step.sv
hw/rtl/rotary_encoder_servo_setpoint_core.sv
hw/rtl/resp_checker.sv
test/tb_top.sv
